[hdl/jss_pkg.sv]
// Shared types and constants for the JSON structure scanner.
// Used by jss_front, jss_queue, jss_back and json_structure_scanner; no dependencies.
package jss_pkg;

	localparam int COUNT_W = 24;
	localparam int DEPTH_W = 16;
	localparam int MAXD_W  = DEPTH_W - 1;
	localparam int NEST_W  = 15;
	localparam int CONT_W  = 25;
	localparam int CFG_W   = 25;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_NEST = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONT = 1'd1;

	localparam logic [NEST_W-1:0] NEST_RESET = 15'd10;
	localparam logic [CONT_W-1:0] CONT_RESET = 25'd1000;

	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;
	localparam logic [7:0] CH_COLON   = 8'h3A;

	localparam int CLS_W = 3;
	localparam logic [CLS_W-1:0] CLS_NONE  = 3'd0;
	localparam logic [CLS_W-1:0] CLS_OBJ   = 3'd1;
	localparam logic [CLS_W-1:0] CLS_ARR   = 3'd2;
	localparam logic [CLS_W-1:0] CLS_CLOSE = 3'd3;
	localparam logic [CLS_W-1:0] CLS_COLON = 3'd4;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [CLS_W-1:0] cls;
		logic             last;
	} jss_item_t;

	typedef struct packed {
		logic [NEST_W-1:0] nest;
		logic [CONT_W-1:0] cont;
	} jss_thr_t;

endpackage

[hdl/jss_front.sv]
// Front end: tracks string and escape state per byte and classifies each byte.
// Depends on jss_pkg.
module jss_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  logic [7:0]             byte_value,
	input  logic                   doc_end,
	output jss_pkg::jss_item_t     item
);

	logic in_str_q;
	logic bs_q;
	logic in_str_n;
	logic bs_n;

	always_comb begin
		in_str_n = in_str_q;
		if (byte_value == jss_pkg::CH_QUOTE && !bs_q)
			in_str_n = ~in_str_q;
		bs_n = (byte_value == jss_pkg::CH_BSLASH) && !bs_q;
	end

	always_comb begin
		item.last = doc_end;
		item.cls  = jss_pkg::CLS_NONE;
		if (!in_str_n) begin
			case (byte_value)
				jss_pkg::CH_LBRACE: item.cls = jss_pkg::CLS_OBJ;
				jss_pkg::CH_LBRACK: item.cls = jss_pkg::CLS_ARR;
				jss_pkg::CH_RBRACE,
				jss_pkg::CH_RBRACK: item.cls = jss_pkg::CLS_CLOSE;
				jss_pkg::CH_COLON:  item.cls = jss_pkg::CLS_COLON;
				default:            item.cls = jss_pkg::CLS_NONE;
			endcase
		end
	end

	// drop string state at document end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_str_q <= 1'b0;
			bs_q     <= 1'b0;
		end else if (take) begin
			in_str_q <= doc_end ? 1'b0 : in_str_n;
			bs_q     <= doc_end ? 1'b0 : bs_n;
		end
	end

endmodule

[hdl/jss_queue.sv]
// Short queue of classified bytes between front and back end.
// Depends on jss_pkg.
module jss_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  jss_pkg::jss_item_t wr_item,
	output logic               full,
	output logic               valid,
	input  logic               rd,
	output jss_pkg::jss_item_t rd_item
);

	jss_pkg::jss_item_t              entry_q [jss_pkg::QDEPTH];
	logic [jss_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [jss_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [jss_pkg::QCNT_W-1:0]      cnt_q;
	logic                            do_wr;
	logic                            do_rd;

	assign full    = (cnt_q == jss_pkg::QCNT_W'(jss_pkg::QDEPTH));
	assign valid   = (cnt_q != '0);
	assign rd_item = entry_q[rd_ptr_q];
	assign do_wr   = wr && !full;
	assign do_rd   = rd && valid;

	always_ff @(posedge clk) begin
		if (do_wr)
			entry_q[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[hdl/jss_back.sv]
// Back end: applies classified bytes to depth and counters, builds the result beat.
// Depends on jss_pkg.
module jss_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	input  jss_pkg::jss_item_t           item,
	output logic                         item_take,
	input  jss_pkg::jss_thr_t            thr,
	input  logic                         pop,
	output logic                         empty,
	output logic [jss_pkg::COUNT_W-1:0]  object_total,
	output logic [jss_pkg::COUNT_W-1:0]  array_total,
	output logic [jss_pkg::COUNT_W-1:0]  key_total,
	output logic [jss_pkg::MAXD_W-1:0]   deepest_level,
	output logic                         deep_flag,
	output logic                         large_flag
);

	localparam logic [jss_pkg::COUNT_W-1:0] COUNT_MAX = {jss_pkg::COUNT_W{1'b1}};
	localparam logic signed [jss_pkg::DEPTH_W-1:0] DEPTH_HI =
		{1'b0, {(jss_pkg::DEPTH_W-1){1'b1}}};
	localparam logic signed [jss_pkg::DEPTH_W-1:0] DEPTH_LO =
		{1'b1, {(jss_pkg::DEPTH_W-1){1'b0}}};

	logic signed [jss_pkg::DEPTH_W-1:0] depth_q, depth_n;
	logic [jss_pkg::MAXD_W-1:0]         max_q, max_n;
	logic [jss_pkg::COUNT_W-1:0]        obj_q, obj_n;
	logic [jss_pkg::COUNT_W-1:0]        arr_q, arr_n;
	logic [jss_pkg::COUNT_W-1:0]        key_q, key_n;
	logic [jss_pkg::CONT_W-1:0]         cont_q, cont_n;
	logic                               out_valid_q;
	logic                               depth_pos;

	assign depth_pos = !depth_q[jss_pkg::DEPTH_W-1] && (depth_q != '0);

	// stall only when a result must be written and the output slot stays full
	assign item_take = item_valid && !(item.last && out_valid_q && !pop);
	assign empty     = !out_valid_q;

	always_comb begin
		depth_n = depth_q;
		obj_n   = obj_q;
		arr_n   = arr_q;
		key_n   = key_q;
		cont_n  = cont_q;
		case (item.cls)
			jss_pkg::CLS_OBJ: begin
				if (obj_q != COUNT_MAX) begin
					obj_n  = obj_q + 1'b1;
					cont_n = cont_q + 1'b1;
				end
				if (depth_q != DEPTH_HI)
					depth_n = depth_q + 1'b1;
			end
			jss_pkg::CLS_ARR: begin
				if (arr_q != COUNT_MAX) begin
					arr_n  = arr_q + 1'b1;
					cont_n = cont_q + 1'b1;
				end
				if (depth_q != DEPTH_HI)
					depth_n = depth_q + 1'b1;
			end
			jss_pkg::CLS_CLOSE: begin
				if (depth_q != DEPTH_LO)
					depth_n = depth_q - 1'b1;
			end
			jss_pkg::CLS_COLON: begin
				if (depth_pos && key_q != COUNT_MAX)
					key_n = key_q + 1'b1;
			end
			default: begin
			end
		endcase
		max_n = max_q;
		if (depth_n > $signed({1'b0, max_q}))
			max_n = depth_n[jss_pkg::MAXD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			max_q   <= '0;
			obj_q   <= '0;
			arr_q   <= '0;
			key_q   <= '0;
			cont_q  <= '0;
		end else if (item_take) begin
			if (item.last) begin
				depth_q <= '0;
				max_q   <= '0;
				obj_q   <= '0;
				arr_q   <= '0;
				key_q   <= '0;
				cont_q  <= '0;
			end else begin
				depth_q <= depth_n;
				max_q   <= max_n;
				obj_q   <= obj_n;
				arr_q   <= arr_n;
				key_q   <= key_n;
				cont_q  <= cont_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (item_take && item.last)
			out_valid_q <= 1'b1;
		else if (pop)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (item_take && item.last) begin
			object_total  <= obj_n;
			array_total   <= arr_n;
			key_total     <= key_n;
			deepest_level <= max_n;
			deep_flag     <= max_n > thr.nest;
			large_flag    <= cont_n > thr.cont;
		end
	end

	a_cont_sum: assert property (@(posedge clk) disable iff (!arst_n)
		cont_q == ({1'b0, obj_q} + {1'b0, arr_q}))
		else $error("container sum out of step with counters");

	a_max_covers_depth: assert property (@(posedge clk) disable iff (!arst_n)
		depth_pos |-> depth_q <= $signed({1'b0, max_q}))
		else $error("maximum depth below current depth");

	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		item_take && item.last |=> depth_q == '0 && obj_q == '0 && key_q == '0)
		else $error("state not cleared after document end");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(item_take && item.last))
		else $error("result beat without a last byte");

endmodule

[hdl/json_structure_scanner.sv]
// Top level of the JSON structure scanner: threshold registers, front end, queue, back end.
// Depends on jss_pkg, jss_front, jss_queue and jss_back.
//
// Scans a JSON document one byte per clock and returns one result beat per
// document, on the byte marked doc_end. Bytes are taken at one per cycle for as
// long as the byte queue (four entries) has room; the back end drains one byte
// per cycle, so push is only held off while a finished result waits to be popped
// and the queue fills behind it. The edge that accepts the last byte of a document
// writes it into the queue; the back end then takes it from the queue and loads
// the result register that drives the output ports. Threshold writes take effect
// at once and should be made while no document is in flight.
module json_structure_scanner (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [7:0]                          byte_value,
	input  logic                                doc_end,
	output logic                                empty,
	input  logic                                pop,
	output logic [jss_pkg::COUNT_W-1:0]         object_total,
	output logic [jss_pkg::COUNT_W-1:0]         array_total,
	output logic [jss_pkg::COUNT_W-1:0]         key_total,
	output logic [jss_pkg::MAXD_W-1:0]          deepest_level,
	output logic                                deep_flag,
	output logic                                large_flag,
	input  logic                                cfg_wr_en,
	input  logic [jss_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [jss_pkg::CFG_W-1:0]           cfg_data
);

	jss_pkg::jss_thr_t  thr_q;
	jss_pkg::jss_item_t front_item;
	jss_pkg::jss_item_t q_item;
	logic               q_valid;
	logic               q_take;
	logic               in_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.nest <= jss_pkg::NEST_RESET;
			thr_q.cont <= jss_pkg::CONT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				jss_pkg::REG_NEST: thr_q.nest <= cfg_data[jss_pkg::NEST_W-1:0];
				jss_pkg::REG_CONT: thr_q.cont <= cfg_data[jss_pkg::CONT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_take = push && !full;

	jss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (in_take),
		.byte_value (byte_value),
		.doc_end    (doc_end),
		.item       (front_item)
	);

	jss_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (push),
		.wr_item (front_item),
		.full    (full),
		.valid   (q_valid),
		.rd      (q_take),
		.rd_item (q_item)
	);

	jss_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (q_valid),
		.item          (q_item),
		.item_take     (q_take),
		.thr           (thr_q),
		.pop           (pop),
		.empty         (empty),
		.object_total  (object_total),
		.array_total   (array_total),
		.key_total     (key_total),
		.deepest_level (deepest_level),
		.deep_flag     (deep_flag),
		.large_flag    (large_flag)
	);

endmodule
